### rtl/positional_list_engine_assert.svh
// Assertion macros shared by the positional list engine modules.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ple_pkg.sv
// Types, codes and defaults shared by the positional list engine modules.
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_W    = 112;
  localparam int unsigned OUT_W   = 120;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ   = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_DELETE = 2'd3
  } ple_req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_POS  = 2'd1,
    STAT_FULL = 2'd2
  } ple_status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;      // capture the request fields
    logic ptr_load;   // set the walk pointer to its start
    logic ptr_step;   // advance the walk pointer
    logic rd_en;      // read the store at the walk pointer
    logic wr_shift;   // move the last read record to its new slot
    logic found_set;  // record the position of the last read record
    logic finish;     // commit the request and load the result
  } ple_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic skip;       // nothing to walk: error, full, or empty walk
    logic last;       // walk pointer sits on the final entry
    logic match;      // last read record matches the search key
    logic out_free;   // result register can take a new result
  } ple_sts_t;

endpackage

### rtl/ple_ctrl.sv
// Request sequencer of the positional list engine.
module ple_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ple_pkg::ple_sts_t sts_i,
  output ple_pkg::ple_cmd_t cmd_o
);

  `include "positional_list_engine_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } ple_state_e;

  ple_state_e state_q, state_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    req_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.skip) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.ptr_load = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.match) begin
          cmd_o.found_set = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          if (sts_i.last) begin
            state_d = S_DRAIN;
          end else begin
            cmd_o.ptr_step = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        cmd_o.wr_shift  = 1'b1;
        cmd_o.found_set = sts_i.match;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PLE_ASSERT_NEXT(a_finish_returns, (state_q == S_FINISH) && sts_i.out_free, state_q == S_IDLE, "finish did not return to idle")

endmodule

### rtl/ple_dp.sv
// Record store, walk pointer, count and result register of the list engine.
module ple_dp #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = ple_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ple_pkg::ple_cmd_t            cmd_i,
  output ple_pkg::ple_sts_t            sts_o,
  input  logic [ple_pkg::REQ_W-1:0]    req_type_i,
  input  logic [ple_pkg::POS_W-1:0]    position_i,
  input  logic [ple_pkg::WORD_W-1:0]   item_key_i,
  input  logic [ple_pkg::WORD_W-1:0]   item_id_i,
  input  logic [ple_pkg::WORD_W-1:0]   item_price_i,
  input  logic                         m_tready_i,
  output logic                         m_tvalid_o,
  output logic [ple_pkg::STAT_W-1:0]   status_o,
  output logic [ple_pkg::POS_W-1:0]    found_position_o,
  output logic [ple_pkg::WORD_W-1:0]   out_key_o,
  output logic [ple_pkg::WORD_W-1:0]   out_id_o,
  output logic [ple_pkg::WORD_W-1:0]   out_price_o,
  output logic [ple_pkg::POS_W-1:0]    list_length_o
);

  `include "positional_list_engine_assert.svh"

  localparam int unsigned KW = (KEY_BITS < ple_pkg::WORD_W) ? KEY_BITS : ple_pkg::WORD_W;
  localparam int unsigned RW = KW + 2 * ple_pkg::WORD_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = CW + ple_pkg::POS_W;
  localparam logic [EW-1:0] ONE_E = EW'(1);
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Request fields
  ple_pkg::ple_req_e            req_q;
  logic [ple_pkg::POS_W-1:0]    pos_q;
  logic [KW-1:0]                key_q;
  logic [ple_pkg::WORD_W-1:0]   id_q;
  logic [ple_pkg::WORD_W-1:0]   price_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] rd_addr_q;
  logic          dv_q;
  logic [RW-1:0] rd_data_q;
  logic [CW-1:0] found_q;
  logic [RW-1:0] mem_q [CAPACITY];

  // Result register
  logic                          m_valid_q;
  ple_pkg::ple_status_e          res_status_q, res_status_d;
  logic [ple_pkg::POS_W-1:0]     res_found_q;
  logic [ple_pkg::WORD_W-1:0]    res_key_q, res_id_q, res_price_q;
  logic [ple_pkg::POS_W-1:0]     res_len_q;

  logic [EW-1:0] pos_e, cnt_e, ptr_e, pos_m1, ptr_start_e;
  logic          is_rd, is_srch, is_ins, is_del;
  logic          bad, full, ins_full, walk_empty, read_ok, ok_commit;
  logic          shift_we, new_we, wr_en, rd_en;
  logic [AW-1:0] shift_addr, wr_addr, rd_addr;
  logic [RW-1:0] wr_data;
  logic [CW+ple_pkg::POS_W-1:0]     found_x, len_x;
  logic [KW+ple_pkg::WORD_W-1:0]    key_x;

  assign is_rd   = (req_q == ple_pkg::REQ_READ);
  assign is_srch = (req_q == ple_pkg::REQ_SEARCH);
  assign is_ins  = (req_q == ple_pkg::REQ_INSERT);
  assign is_del  = (req_q == ple_pkg::REQ_DELETE);

  assign pos_e  = {{CW{1'b0}}, pos_q};
  assign cnt_e  = {{ple_pkg::POS_W{1'b0}}, count_q};
  assign ptr_e  = {{(EW-AW){1'b0}}, ptr_q};
  assign pos_m1 = pos_e - ONE_E;

  // Position checks against the current length
  always_comb begin
    if (is_srch) begin
      bad = 1'b0;
    end else if (pos_e == '0) begin
      bad = 1'b1;
    end else if (is_ins) begin
      bad = (pos_e > cnt_e + ONE_E);
    end else begin
      bad = (pos_e > cnt_e);
    end
  end

  assign full     = (cnt_e == CAP_E);
  assign ins_full = is_ins & full;

  always_comb begin
    case (req_q)
      ple_pkg::REQ_SEARCH: begin
        walk_empty  = (cnt_e == '0);
        ptr_start_e = '0;
      end
      ple_pkg::REQ_INSERT: begin
        walk_empty  = (pos_e == cnt_e + ONE_E);
        ptr_start_e = cnt_e - ONE_E;
      end
      ple_pkg::REQ_DELETE: begin
        walk_empty  = (pos_e == cnt_e);
        ptr_start_e = pos_e;
      end
      default: begin
        walk_empty  = 1'b0;
        ptr_start_e = pos_m1;
      end
    endcase
  end

  assign sts_o.skip     = bad | ins_full | walk_empty;
  assign sts_o.last     = is_rd | (is_ins ? (ptr_e == pos_m1) : (ptr_e == cnt_e - ONE_E));
  assign sts_o.match    = is_srch & dv_q & (rd_data_q[KW-1:0] == key_q);
  assign sts_o.out_free = ~m_valid_q | m_tready_i;

  // Store writes: shifted records during the walk, the new record at commit
  assign read_ok    = is_rd & ~bad;
  assign ok_commit  = cmd_i.finish & ~bad & ~ins_full;
  assign shift_we   = cmd_i.wr_shift & dv_q & (is_ins | is_del);
  assign shift_addr = is_ins ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
  assign new_we     = ok_commit & is_ins;
  assign wr_en      = shift_we | new_we;
  assign wr_addr    = new_we ? pos_m1[AW-1:0] : shift_addr;
  assign wr_data    = new_we ? {price_q, id_q, key_q} : rd_data_q;
  assign rd_en      = cmd_i.rd_en;
  assign rd_addr    = ptr_q;

  always_comb begin
    count_d = count_q;
    if (ok_commit && is_ins) begin
      count_d = count_q + CW'(1);
    end else if (ok_commit && is_del) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    if (bad) begin
      res_status_d = ple_pkg::STAT_POS;
    end else if (ins_full) begin
      res_status_d = ple_pkg::STAT_FULL;
    end else begin
      res_status_d = ple_pkg::STAT_OK;
    end
  end

  assign found_x = {{ple_pkg::POS_W{1'b0}}, found_q};
  assign len_x   = {{ple_pkg::POS_W{1'b0}}, count_d};
  assign key_x   = {{ple_pkg::WORD_W{1'b0}}, rd_data_q[KW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= ple_pkg::ple_req_e'(req_type_i);
      pos_q   <= position_i;
      key_q   <= item_key_i[KW-1:0];
      id_q    <= item_id_i;
      price_q <= item_price_i;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= ptr_start_e[AW-1:0];
    end else if (cmd_i.ptr_step) begin
      ptr_q <= is_ins ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
    if (cmd_i.latch) begin
      found_q <= '0;
    end else if (cmd_i.found_set) begin
      found_q <= CW'(rd_addr_q) + CW'(1);
    end
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_found_q  <= found_x[ple_pkg::POS_W-1:0];
      res_key_q    <= read_ok ? key_x[ple_pkg::WORD_W-1:0] : '0;
      res_id_q     <= read_ok ? rd_data_q[KW+ple_pkg::WORD_W-1:KW] : '0;
      res_price_q  <= read_ok ? rd_data_q[RW-1:KW+ple_pkg::WORD_W] : '0;
      res_len_q    <= len_x[ple_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      dv_q    <= rd_en;
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o       = m_valid_q;
  assign status_o         = res_status_q;
  assign found_position_o = res_found_q;
  assign out_key_o        = res_key_q;
  assign out_id_o         = res_id_q;
  assign out_price_o      = res_price_q;
  assign list_length_o    = res_len_q;

  `PLE_ASSERT_NOW(a_load_when_free, cmd_i.finish, !m_valid_q || m_tready_i, "result overwritten before taken")
  `PLE_ASSERT_NEXT(a_count_hold, !cmd_i.finish, $stable(count_q), "length changed outside commit")
  `PLE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CAP_C, "length above capacity")
  `PLE_ASSERT_NOW(a_no_rw_clash, shift_we && rd_en, wr_addr != rd_addr, "shift writes the entry being read")

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: stream ports, sequencer and datapath.
//
// Keeps an ordered list of up to CAPACITY records (key, id, price) in one
// record memory and serves one request at a time from the slave stream:
// read a 1-based position, search for the first matching key, insert at a
// position (1..length+1) or delete at a position (1..length).
// Each request gives exactly one result on the master stream with a status
// (ok, position out of range, list full), the search position, the record
// read and the list length after the request. Failed requests leave the list
// unchanged.
// A read fetches its one record; search walks the list from the front until
// a match, insert and delete walk only the records they move, as the walk
// moves one record per cycle; a rejected request or one with nothing to move
// skips the walk.
// s_axis_tready is high only while no request is in progress. The result sits
// in an output register: a stalled receiver does not block the next request
// from being accepted and worked, only its final commit waits until the
// register frees up.
// Reset clears the length and the result valid; record memory is not cleared
// and needs no clearing pass, as only entries below the length are read.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = ple_pkg::KEY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type[1:0], position[9:2], item_key[41:10], item_id[73:42],
  // item_price[105:74], zero fill[111:106]
  input  logic [ple_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[1:0], found_position[9:2], out_key[41:10], out_id[73:42],
  // out_price[105:74], list_length[113:106], zero fill[119:114]
  output logic [ple_pkg::OUT_W-1:0]  m_axis_tdata
);

  ple_pkg::ple_cmd_t cmd;
  ple_pkg::ple_sts_t sts;

  logic [ple_pkg::STAT_W-1:0]  status;
  logic [ple_pkg::POS_W-1:0]   found_position;
  logic [ple_pkg::WORD_W-1:0]  out_key, out_id, out_price;
  logic [ple_pkg::POS_W-1:0]   list_length;

  // Sequence each request: check, walk the memory, commit, hand off result
  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Unpack the request fields straight from the slave data bus
  ple_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (s_axis_tdata[1:0]),
    .position_i       (s_axis_tdata[9:2]),
    .item_key_i       (s_axis_tdata[41:10]),
    .item_id_i        (s_axis_tdata[73:42]),
    .item_price_i     (s_axis_tdata[105:74]),
    .m_tready_i       (m_axis_tready),
    .m_tvalid_o       (m_axis_tvalid),
    .status_o         (status),
    .found_position_o (found_position),
    .out_key_o        (out_key),
    .out_id_o         (out_id),
    .out_price_o      (out_price),
    .list_length_o    (list_length)
  );

  // Pack the result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {6'b0, list_length, out_price, out_id, out_key,
                         found_position, status};

endmodule
